@@ sv/affrot_pkg.sv @@
// Shared widths, register codes, reset values and types of the rotating block sampler.
package affrot_pkg;

    localparam int STEP_W    = 14;
    localparam int ADDR_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int COL_W     = 8;
    localparam int ROW_W     = 7;
    localparam int CFG_IDX_W = 1;

    // half step plus col * step stays inside 23 signed bits for any 14-bit step
    localparam int PROD_W  = 23;
    localparam int COORD_W = 24;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 4 * BYTE_W;

    localparam int SRC_WIDTH_DEF  = 320;
    localparam int SRC_HEIGHT_DEF = 200;
    localparam int FRAC_BITS_DEF  = 10;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_A = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_B = 1'd1;

    localparam logic signed [STEP_W-1:0] STEP_A_RST = 14'sd2048;
    localparam logic signed [STEP_W-1:0] STEP_B_RST = 14'sd0;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_RENDER = 1'b1;

    typedef struct packed {
        logic wr;
        logic rd;
    } bank_ctl_t;

endpackage

@@ sv/affine_rotate_block_sampler_core.sv @@
// Rotating 2x2 block sampler: image store load path and fixed-point rotation pipeline.
//
// Takes one item per clock unless stalled; yields one result per render item, none per
// load. Stages move independently, so bubbles close up under backpressure. The rate is
// set by the image store, split into four banks by column and row parity: each 2x2
// block touches every bank once, and each bank does one access a cycle. A load splits
// its address into row and column through a reciprocal multiply with one correction
// step. The store is not cleared after reset; read only pixels that were loaded. The
// user writes step_a and step_b on the cfg port with no item in flight (not enforced).
module affine_rotate_block_sampler_core #(
    parameter int SRC_WIDTH  = affrot_pkg::SRC_WIDTH_DEF,
    parameter int SRC_HEIGHT = affrot_pkg::SRC_HEIGHT_DEF,
    parameter int FRAC_BITS  = affrot_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [affrot_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [affrot_pkg::STEP_W-1:0]       cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // load_address[15:0], load_byte[23:16], out_col[31:24], out_row[38:32], zero[39]
    input  logic [affrot_pkg::S_TDATA_W-1:0]    s_tdata,
    // kind
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pixel_top_left[7:0], pixel_top_right[15:8], pixel_bottom_left[23:16],
    // pixel_bottom_right[31:24]
    output logic [affrot_pkg::M_TDATA_W-1:0]    m_tdata,
    // clipped
    output logic                                m_tuser
);
    import affrot_pkg::*;

    localparam int XW         = $clog2(SRC_WIDTH);
    localparam int YW         = $clog2(SRC_HEIGHT);
    localparam int HALF_W     = (SRC_WIDTH + 1) / 2;
    localparam int HALF_H     = (SRC_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH = HALF_W * HALF_H;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int STORE_SIZE = SRC_WIDTH * SRC_HEIGHT;
    localparam int DIV_SHIFT  = ADDR_W + XW;
    localparam int RECIP_W    = ADDR_W + 1;
    localparam int DIVP_W     = ADDR_W + RECIP_W;
    localparam longint unsigned RECIP = (64'd1 << DIV_SHIFT) / SRC_WIDTH;

    localparam logic signed [COORD_W-1:0] C_MIN  = COORD_W'(1);
    localparam logic signed [COORD_W-1:0] X_MAX  = COORD_W'(SRC_WIDTH - 2);
    localparam logic signed [COORD_W-1:0] Y_MAX  = COORD_W'(SRC_HEIGHT - 2);

    // ---------------- configuration ----------------
    logic signed [STEP_W-1:0] step_a_reg, step_b_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_a_reg <= STEP_A_RST;
            step_b_reg <= STEP_B_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_STEP_A: step_a_reg <= cfg_data;
                REG_STEP_B: step_b_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- input unpack ----------------
    logic [ADDR_W-1:0] in_addr;
    logic [BYTE_W-1:0] in_byte;
    logic [COL_W-1:0]  in_col;
    logic [ROW_W-1:0]  in_row;

    assign in_addr = s_tdata[ADDR_W-1:0];
    assign in_byte = s_tdata[ADDR_W +: BYTE_W];
    assign in_col  = s_tdata[ADDR_W+BYTE_W +: COL_W];
    assign in_row  = s_tdata[ADDR_W+BYTE_W+COL_W +: ROW_W];

    // ---------------- stage enables ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, m_valid_reg;
    logic en1, en2, en3, en4, en5, en6, en7;
    logic kind5_reg;

    assign en7 = !m_valid_reg || m_tready;
    assign en6 = !v6_reg || en7;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg && (kind5_reg == KIND_RENDER);
            if (en7) m_valid_reg <= v6_reg;
        end
    end

    // ---------------- stage 1: products ----------------
    logic                     kind1_reg, inr1_reg;
    logic [ADDR_W-1:0]        addr1_reg;
    logic [BYTE_W-1:0]        byte1_reg;
    logic [DIVP_W-1:0]        divp_reg;
    logic signed [PROD_W-1:0] p_ac_reg, p_bc_reg, p_ar_reg, p_br_reg;
    logic signed [COL_W:0]    col_s;
    logic signed [ROW_W:0]    row_s;

    assign col_s = signed'({1'b0, in_col});
    assign row_s = signed'({1'b0, in_row});

    always_ff @(posedge aclk) begin
        if (en1) begin
            kind1_reg <= s_tuser;
            inr1_reg  <= 32'(in_addr) < 32'(STORE_SIZE);
            addr1_reg <= in_addr;
            byte1_reg <= in_byte;
            divp_reg  <= DIVP_W'(in_addr) * DIVP_W'(RECIP);
            p_ac_reg  <= PROD_W'(col_s) * PROD_W'(step_a_reg);
            p_bc_reg  <= PROD_W'(col_s) * PROD_W'(step_b_reg);
            p_ar_reg  <= PROD_W'(row_s) * PROD_W'(step_a_reg);
            p_br_reg  <= PROD_W'(row_s) * PROD_W'(step_b_reg);
        end
    end

    // ---------------- stage 2: round terms, quotient estimate ----------------
    logic signed [PROD_W-1:0]  half_a, half_b;
    logic signed [PROD_W-1:0]  s_ac, s_bc, s_ar, s_br;
    logic [ADDR_W-1:0]         q_next, qw_next;
    logic signed [COORD_W-1:0] t_ac_reg, t_bc_reg, t_ar_reg, t_br_reg;
    logic                      kind2_reg, inr2_reg;
    logic [ADDR_W-1:0]         addr2_reg, q2_reg, qw2_reg;
    logic [BYTE_W-1:0]         byte2_reg;

    always_comb begin
        half_a  = PROD_W'(step_a_reg >>> 1);
        half_b  = PROD_W'(step_b_reg >>> 1);
        s_ac    = half_a + p_ac_reg;
        s_bc    = half_b + p_bc_reg;
        s_ar    = half_a + p_ar_reg;
        s_br    = half_b + p_br_reg;
        // estimate is exact or one low; q*W never exceeds the address
        q_next  = ADDR_W'(divp_reg >> DIV_SHIFT);
        qw_next = q_next * ADDR_W'(SRC_WIDTH);
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            t_ac_reg  <= COORD_W'(s_ac >>> FRAC_BITS);
            t_bc_reg  <= COORD_W'(s_bc >>> FRAC_BITS);
            t_ar_reg  <= COORD_W'(s_ar >>> FRAC_BITS);
            t_br_reg  <= COORD_W'(s_br >>> FRAC_BITS);
            kind2_reg <= kind1_reg;
            inr2_reg  <= inr1_reg;
            addr2_reg <= addr1_reg;
            q2_reg    <= q_next;
            qw2_reg   <= qw_next;
            byte2_reg <= byte1_reg;
        end
    end

    // ---------------- stage 3: source position, clip, load row/col ----------------
    logic signed [COORD_W-1:0] sx_next, sy_next;
    logic                      clip_next, fix;
    logic [ADDR_W-1:0]         r0, rl, ql;
    logic [XW-1:0]             x_next;
    logic [YW-1:0]             y_next;
    logic                      kind3_reg, inr3_reg, clip3_reg;
    logic [XW-1:0]             x3_reg;
    logic [YW-1:0]             y3_reg;
    logic [BYTE_W-1:0]         byte3_reg;

    always_comb begin
        sx_next   = t_ac_reg - t_br_reg;
        sy_next   = t_bc_reg + t_ar_reg;
        clip_next = (sx_next < C_MIN) || (sx_next > X_MAX) ||
                    (sy_next < C_MIN) || (sy_next > Y_MAX);
        r0  = addr2_reg - qw2_reg;
        fix = r0 >= ADDR_W'(SRC_WIDTH);
        rl  = fix ? r0 - ADDR_W'(SRC_WIDTH) : r0;
        ql  = q2_reg + ADDR_W'(fix);
        if (kind2_reg == KIND_RENDER) begin
            x_next = sx_next[XW-1:0];
            y_next = sy_next[YW-1:0];
        end else begin
            x_next = rl[XW-1:0];
            y_next = ql[YW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            kind3_reg <= kind2_reg;
            inr3_reg  <= inr2_reg;
            clip3_reg <= clip_next;
            x3_reg    <= x_next;
            y3_reg    <= y_next;
            byte3_reg <= byte2_reg;
        end
    end

    // ---------------- stage 4: bank rows and columns ----------------
    // parity-0 banks hold the even one of {s, s+1}: half index (s+1)>>1; parity-1: s>>1
    logic [YW:0]          hy0_sum;
    logic [XW:0]          hx0_sum;
    logic [YW-1:0]        hy0, hy1;
    logic [BANK_AW-1:0]   rb0_reg, rb1_reg;
    logic [XW-1:0]        hx0_reg, hx1_reg;
    logic                 kind4_reg, inr4_reg, clip4_reg, px4_reg, py4_reg;
    logic [BYTE_W-1:0]    byte4_reg;

    always_comb begin
        hy0_sum = (YW+1)'(y3_reg) + (YW+1)'(kind3_reg == KIND_RENDER);
        hx0_sum = (XW+1)'(x3_reg) + (XW+1)'(kind3_reg == KIND_RENDER);
        hy0     = hy0_sum[YW:1];
        hy1     = y3_reg >> 1;
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            rb0_reg   <= BANK_AW'(32'(hy0) * 32'(HALF_W));
            rb1_reg   <= BANK_AW'(32'(hy1) * 32'(HALF_W));
            hx0_reg   <= hx0_sum[XW:1];
            hx1_reg   <= x3_reg >> 1;
            kind4_reg <= kind3_reg;
            inr4_reg  <= inr3_reg;
            clip4_reg <= clip3_reg;
            px4_reg   <= x3_reg[0];
            py4_reg   <= y3_reg[0];
            byte4_reg <= byte3_reg;
        end
    end

    // ---------------- stage 5: bank addresses ----------------
    // bank index is {row parity, column parity}
    logic [BANK_AW-1:0] baddr_next [4];
    logic [BANK_AW-1:0] baddr_reg  [4];
    logic [3:0]         wr_next, wr5_reg;
    logic               rd5_reg, clip5_reg, px5_reg, py5_reg;
    logic [BYTE_W-1:0]  byte5_reg;

    always_comb begin
        for (int b = 0; b < 4; b++) begin
            baddr_next[b] = ((b & 2) != 0 ? rb1_reg : rb0_reg) +
                            BANK_AW'((b & 1) != 0 ? hx1_reg : hx0_reg);
            wr_next[b]    = (kind4_reg == KIND_LOAD) && inr4_reg &&
                            ({py4_reg, px4_reg} == 2'(b));
        end
    end

    always_ff @(posedge aclk) begin
        if (en5) begin
            for (int b = 0; b < 4; b++) begin
                baddr_reg[b] <= baddr_next[b];
            end
            wr5_reg   <= wr_next;
            rd5_reg   <= (kind4_reg == KIND_RENDER) && !clip4_reg;
            kind5_reg <= kind4_reg;
            clip5_reg <= clip4_reg;
            px5_reg   <= px4_reg;
            py5_reg   <= py4_reg;
            byte5_reg <= byte4_reg;
        end
    end

    // ---------------- stage 6: image store banks ----------------
    logic [BYTE_W-1:0] bdata [4];
    logic              clip6_reg, px6_reg, py6_reg;

    for (genvar g = 0; g < 4; g++) begin : g_bank
        bank_ctl_t ctl;

        assign ctl.wr = en6 && v5_reg && wr5_reg[g];
        assign ctl.rd = en6 && v5_reg && rd5_reg;

        affrot_bank #(
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .aclk  (aclk),
            .ctl   (ctl),
            .addr  (baddr_reg[g]),
            .wdata (byte5_reg),
            .rdata (bdata[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (en6) begin
            clip6_reg <= clip5_reg;
            px6_reg   <= px5_reg;
            py6_reg   <= py5_reg;
        end
    end

    // ---------------- stage 7: output register ----------------
    logic [M_TDATA_W-1:0] m_data_next, m_data_reg;
    logic                 m_clip_reg;

    always_comb begin
        if (clip6_reg) begin
            m_data_next = '0;
        end else begin
            m_data_next = {bdata[{!py6_reg, !px6_reg}], bdata[{!py6_reg, px6_reg}],
                           bdata[{py6_reg, !px6_reg}],  bdata[{py6_reg, px6_reg}]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en7) begin
            m_data_reg <= m_data_next;
            m_clip_reg <= clip6_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_clip_reg;

endmodule

@@ sv/affrot_bank.sv @@
// One parity bank of the image store: up to one write and one registered read per cycle.
module affrot_bank #(
    parameter int DEPTH = ((affrot_pkg::SRC_WIDTH_DEF + 1) / 2) *
                          ((affrot_pkg::SRC_HEIGHT_DEF + 1) / 2),
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                            aclk,
    input  affrot_pkg::bank_ctl_t           ctl,
    input  logic [AW-1:0]                   addr,
    input  logic [affrot_pkg::BYTE_W-1:0]   wdata,
    output logic [affrot_pkg::BYTE_W-1:0]   rdata
);
    import affrot_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr) begin
            mem[addr] <= wdata;
        end
        if (ctl.rd) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/affrot_checker.sv @@
// Port-level checks for the rotating block sampler, bound to its top level.
module affrot_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [affrot_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic                                m_tuser
);
    import affrot_pkg::*;

    // a waiting result holds still
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // clipped results carry zero pixels
    a_clip_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("clipped result with nonzero pixels");

    // an empty or draining output never blocks the input side
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input stalled while output can move");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind affine_rotate_block_sampler_core affrot_checker u_affrot_checker (.*);
